FILE: rtl/itp_pkg.sv
// Package for the infix to postfix converter: operator codes, ASCII constants,
// stack sizing and operator lookup functions. No dependencies.
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CODE_W      = 3;

  typedef enum logic [CODE_W-1:0] {
    OP_OPEN = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POW  = 3'd5
  } op_code_e;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;

  function automatic logic [7:0] code_char(input logic [CODE_W-1:0] code);
    case (code)
      OP_OPEN: code_char = CH_OPEN;
      OP_ADD:  code_char = CH_ADD;
      OP_SUB:  code_char = CH_SUB;
      OP_MUL:  code_char = CH_MUL;
      OP_DIV:  code_char = CH_DIV;
      OP_POW:  code_char = CH_POW;
      default: code_char = 8'h00;
    endcase
  endfunction

  function automatic logic [1:0] code_prec(input logic [CODE_W-1:0] code);
    case (code) inside
      OP_ADD, OP_SUB: code_prec = 2'd1;
      OP_MUL, OP_DIV: code_prec = 2'd2;
      OP_POW:         code_prec = 2'd3;
      default:        code_prec = 2'd0;
    endcase
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

FILE: rtl/itp_stack.sv
// Operator stack memory: one write port, one read port, registered read data
// with write-to-read forwarding. Depends on itp_pkg.
module itp_stack import itp_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [CODE_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [CODE_W-1:0] rdata_o
);

  logic [CODE_W-1:0] mem [STACK_DEPTH];
  logic [CODE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // a push and a read of the same entry in one cycle return the pushed code
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/infix_to_postfix_converter_top.sv
// Shunting-yard infix to postfix converter, top level.
// Depends on itp_pkg and itp_stack.
//
// Characters arrive one per request; tlast marks the end of an expression. A
// space, tab, ignored character, letter, digit or '(' is handled as it is
// accepted. A ')' or operator is accepted and then examines stack entries one
// at a time in ST_POP (each pop, plus the final compare or push). The character
// marked last then pops each entry left on the stack in ST_FLUSH, finds the
// stack empty and sends the end result, which carries bad_expr, in ST_END. The
// operator stack memory, read once per cycle with registered read data, sets
// this pace. Results also wait on m_axis_tready.
module infix_to_postfix_converter_top import itp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_in
  input  logic       s_axis_tlast,   // is_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] symbol_out
  output logic [1:0] m_axis_tuser,   // [0] has_symbol, [1] bad_expr
  output logic       m_axis_tlast    // end_of_expr
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_FLUSH,
    ST_END
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              err_q, err_d;
  logic              last_q, last_d;
  logic              close_q, close_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic              pend_valid_q, pend_valid_d;
  logic [7:0]        pend_sym_q, pend_sym_d;
  logic              m_valid_q, m_valid_d;
  logic [7:0]        m_data_q, m_data_d;
  logic [1:0]        m_user_q, m_user_d;
  logic              m_last_q, m_last_d;

  logic              can_emit;
  logic              prod;
  logic [7:0]        prod_sym;
  logic              prod_last;
  logic              push;
  logic [CODE_W-1:0] push_code;
  logic              we;
  logic [CODE_W-1:0] wdata;
  logic [CNT_W-1:0]  rd_ptr;
  logic [CODE_W-1:0] top;
  logic              full;
  logic [7:0]        c_in;

  assign can_emit      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && can_emit;
  assign full          = (cnt_q == CNT_W'(STACK_DEPTH));
  assign c_in          = s_axis_tdata;
  assign rd_ptr        = cnt_d - CNT_W'(1);

  itp_stack u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (rd_ptr[ADDR_W-1:0]),
    .rdata_o (top)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    err_d        = err_q;
    last_d       = last_q;
    close_d      = close_q;
    code_d       = code_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_data_d     = m_data_q;
    m_user_d     = m_user_q;
    m_last_d     = m_last_q;
    prod         = 1'b0;
    prod_sym     = 8'h00;
    prod_last    = last_q;
    push         = 1'b0;
    push_code    = OP_OPEN;
    we           = 1'b0;
    wdata        = OP_OPEN;

    unique case (state_q)
      ST_IDLE: begin
        prod_last = s_axis_tlast;
        if (s_axis_tvalid && s_axis_tready) begin
          last_d  = s_axis_tlast;
          state_d = s_axis_tlast ? ST_FLUSH : ST_IDLE;
          if (is_alnum(c_in)) begin
            prod     = 1'b1;
            prod_sym = c_in;
          end else begin
            case (c_in) inside
              CH_OPEN: begin
                push      = 1'b1;
                push_code = OP_OPEN;
              end
              CH_CLOSE: begin
                close_d = 1'b1;
                state_d = ST_POP;
              end
              CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_POW: begin
                close_d = 1'b0;
                state_d = ST_POP;
                case (c_in)
                  CH_ADD:  code_d = OP_ADD;
                  CH_SUB:  code_d = OP_SUB;
                  CH_MUL:  code_d = OP_MUL;
                  CH_DIV:  code_d = OP_DIV;
                  default: code_d = OP_POW;
                endcase
              end
              default: ;
            endcase
          end
        end
      end

      ST_POP: begin
        if (cnt_q == '0) begin
          if (close_q) begin
            err_d = 1'b1;            // close bracket without an open one
          end else begin
            push      = 1'b1;
            push_code = code_q;
          end
          state_d = last_q ? ST_FLUSH : ST_IDLE;
        end else if (close_q) begin
          if (top == OP_OPEN) begin
            cnt_d   = cnt_q - CNT_W'(1);
            state_d = last_q ? ST_FLUSH : ST_IDLE;
          end else if (can_emit) begin
            prod     = 1'b1;
            prod_sym = code_char(top);
            cnt_d    = cnt_q - CNT_W'(1);
          end
        end else if (code_prec(top) >= code_prec(code_q)) begin
          if (can_emit) begin
            prod     = 1'b1;
            prod_sym = code_char(top);
            cnt_d    = cnt_q - CNT_W'(1);
          end
        end else begin
          push      = 1'b1;
          push_code = code_q;
          state_d   = last_q ? ST_FLUSH : ST_IDLE;
        end
      end

      ST_FLUSH: begin
        if (cnt_q == '0) begin
          state_d = ST_END;
        end else if (top == OP_OPEN) begin
          err_d = 1'b1;              // open bracket never closed
          cnt_d = cnt_q - CNT_W'(1);
        end else if (can_emit) begin
          prod     = 1'b1;
          prod_sym = code_char(top);
          cnt_d    = cnt_q - CNT_W'(1);
        end
      end

      ST_END: begin
        if (can_emit) begin
          m_valid_d    = 1'b1;
          m_data_d     = pend_valid_q ? pend_sym_q : 8'h00;
          m_user_d     = {err_q, pend_valid_q};
          m_last_d     = 1'b1;
          err_d        = 1'b0;
          cnt_d        = '0;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (push) begin
      if (full) begin
        err_d = 1'b1;
      end else begin
        we    = 1'b1;
        wdata = push_code;
        cnt_d = cnt_q + CNT_W'(1);
      end
    end

    // within the final character, one symbol is held back so the end flags
    // can go on the last one
    if (prod) begin
      if (prod_last) begin
        if (pend_valid_q) begin
          m_valid_d = 1'b1;
          m_data_d  = pend_sym_q;
          m_user_d  = 2'b01;
          m_last_d  = 1'b0;
        end
        pend_valid_d = 1'b1;
        pend_sym_d   = prod_sym;
      end else begin
        m_valid_d = 1'b1;
        m_data_d  = prod_sym;
        m_user_d  = 2'b01;
        m_last_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      err_q        <= 1'b0;
      last_q       <= 1'b0;
      close_q      <= 1'b0;
      code_q       <= OP_OPEN;
      pend_valid_q <= 1'b0;
      pend_sym_q   <= 8'h00;
      m_valid_q    <= 1'b0;
      m_data_q     <= 8'h00;
      m_user_q     <= 2'b00;
      m_last_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      err_q        <= err_d;
      last_q       <= last_d;
      close_q      <= close_d;
      code_q       <= code_d;
      pend_valid_q <= pend_valid_d;
      pend_sym_q   <= pend_sym_d;
      m_valid_q    <= m_valid_d;
      m_data_q     <= m_data_d;
      m_user_q     <= m_user_d;
      m_last_q     <= m_last_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

endmodule

FILE: tb/infix_to_postfix_converter_top_tb.sv
// Self-checking testbench for infix_to_postfix_converter_top: streams infix text in,
// predicts the postfix output with its own shunting-yard model and checks each result.
// Depends on itp_pkg and the converter RTL.
module infix_to_postfix_converter_top_tb import itp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] symbol;
    logic       has_symbol;
    logic       bad_expr;
    logic       end_of_expr;
  } postfix_sym_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         drain_first;   // hold this request until every result is back
  } char_req_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  infix_to_postfix_converter_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  op_code_e     opr_stack [STACK_DEPTH];
  int unsigned  opr_depth = 0;
  bit           opr_fault = 1'b0;
  postfix_sym_t pending_syms[$];

  int unsigned  mismatches = 0;
  int unsigned  inputs_taken = 0;
  int unsigned  total_items = 0;
  bit           calm_tail = 1'b0;

  function automatic int rank(input op_code_e k);
    case (k) inside
      OP_ADD, OP_SUB: return 1;
      OP_MUL, OP_DIV: return 2;
      OP_POW:         return 3;
      default:        return 0;
    endcase
  endfunction

  function automatic logic [7:0] glyph(input op_code_e k);
    case (k)
      OP_ADD:  return CH_ADD;
      OP_SUB:  return CH_SUB;
      OP_MUL:  return CH_MUL;
      OP_DIV:  return CH_DIV;
      OP_POW:  return CH_POW;
      default: return CH_OPEN;
    endcase
  endfunction

  function automatic bit is_operand(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic postfix_sym_t plain_sym(input logic [7:0] c);
    return '{symbol: c, has_symbol: 1'b1, bad_expr: 1'b0, end_of_expr: 1'b0};
  endfunction

  function automatic void push_op(input op_code_e k);
    if (opr_depth >= STACK_DEPTH) begin
      opr_fault = 1'b1;   // push onto a full stack is dropped
    end else begin
      opr_stack[opr_depth] = k;
      opr_depth++;
    end
  endfunction

  // Runs one character through the shunting-yard rule and queues its results.
  task automatic convert_char(input logic [7:0] c, input logic last);
    postfix_sym_t outq[$];
    op_code_e     k;
    bit           is_op;
    is_op = 1'b1;
    k = OP_OPEN;
    case (c)
      CH_ADD:  k = OP_ADD;
      CH_SUB:  k = OP_SUB;
      CH_MUL:  k = OP_MUL;
      CH_DIV:  k = OP_DIV;
      CH_POW:  k = OP_POW;
      default: is_op = 1'b0;
    endcase
    if (c == CH_SPACE || c == CH_TAB) begin
    end else if (is_operand(c)) begin
      outq.push_back(plain_sym(c));
    end else if (c == CH_OPEN) begin
      push_op(OP_OPEN);
    end else if (c == CH_CLOSE) begin
      while (opr_depth > 0 && opr_stack[opr_depth-1] != OP_OPEN) begin
        opr_depth--;
        outq.push_back(plain_sym(glyph(opr_stack[opr_depth])));
      end
      if (opr_depth > 0) opr_depth--;
      else opr_fault = 1'b1;
    end else if (is_op) begin
      while (opr_depth > 0 && rank(opr_stack[opr_depth-1]) >= rank(k)) begin
        opr_depth--;
        outq.push_back(plain_sym(glyph(opr_stack[opr_depth])));
      end
      push_op(k);
    end
    if (last) begin
      while (opr_depth > 0) begin
        opr_depth--;
        if (opr_stack[opr_depth] == OP_OPEN) opr_fault = 1'b1;
        else outq.push_back(plain_sym(glyph(opr_stack[opr_depth])));
      end
      if (outq.size() == 0) outq.push_back('0);
      outq[outq.size()-1].bad_expr = opr_fault;
      outq[outq.size()-1].end_of_expr = 1'b1;
      opr_depth = 0;
      opr_fault = 1'b0;
    end
    foreach (outq[i]) pending_syms.push_back(outq[i]);
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("%0t ns mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------- stimulus build
  char_req_t  item_q[$];
  logic [7:0] draft[$];

  function automatic logic [7:0] pick_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    return 8'("a" + r - 36);
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 4))
      0:       return CH_ADD;
      1:       return CH_SUB;
      2:       return CH_MUL;
      3:       return CH_DIV;
      default: return CH_POW;
    endcase
  endfunction

  function automatic void maybe_blank();
    if ($urandom_range(0, 5) == 0) draft.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endfunction

  task automatic gen_operand(input int lvl);
    if (lvl < 3 && $urandom_range(0, 3) == 0) begin
      draft.push_back(CH_OPEN);
      gen_expr(lvl + 1);
      draft.push_back(CH_CLOSE);
    end else begin
      draft.push_back(pick_alnum());
    end
  endtask

  task automatic gen_expr(input int lvl);
    int n;
    n = $urandom_range(0, 3);
    gen_operand(lvl);
    repeat (n) begin
      maybe_blank();
      draft.push_back(pick_op());
      maybe_blank();
      gen_operand(lvl);
    end
  endtask

  // Nested "(a+(b*(c..." text; past about 16 levels the stack overflows.
  task automatic gen_deep(input int levels);
    repeat (levels) begin
      draft.push_back(CH_OPEN);
      draft.push_back(pick_alnum());
      draft.push_back(pick_op());
    end
    draft.push_back(pick_alnum());
    repeat ($urandom_range(0, levels)) draft.push_back(CH_CLOSE);
  endtask

  // Breaks a well-formed text now and then: a stray byte, a lost char, an extra bracket.
  function automatic void corrupt();
    int pos;
    pos = $urandom_range(0, draft.size() - 1);
    case ($urandom_range(0, 9))
      0: draft[pos] = 8'($urandom_range(0, 255));
      1: if (draft.size() > 1) draft.delete(pos);
      2: draft.insert(pos, CH_CLOSE);
      3: draft.insert(pos, CH_OPEN);
      default: ;
    endcase
  endfunction

  function automatic void commit_draft(input bit drain);
    foreach (draft[i]) item_q.push_back('{draft[i], i == draft.size() - 1, drain && i == 0});
    draft.delete();
  endfunction

  function automatic void add_string(input string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
    commit_draft(1'b0);
  endfunction

  // ---------------------------------------------------------------- driver
  char_req_t   cur = '{8'h00, 1'b0, 1'b0};
  bit          offering = 1'b0;
  int unsigned src_gap = 0;
  int unsigned src_rate = 0;

  always begin
    @(posedge clk_i);
    if (s_axis_tvalid && s_axis_tready) begin
      offering = 1'b0;
      if (inputs_taken % 16 == 0) src_rate = $urandom_range(0, 3);
      if (!calm_tail && src_rate != 0 && $urandom_range(0, 7) < src_rate)
        src_gap = $urandom_range(1, 17);
    end
    @(negedge clk_i);
    if (!offering && rst_ni && item_q.size() != 0) begin
      if (src_gap != 0) begin
        src_gap--;
      end else if (!(item_q[0].drain_first && pending_syms.size() != 0)) begin
        cur = item_q.pop_front();
        offering = 1'b1;
      end
    end
    s_axis_tvalid <= offering;
    s_axis_tdata  <= cur.ch;
    s_axis_tlast  <= cur.last;
  end

  // ---------------------------------------------------------------- receiver
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned sink_stall = 0;
  int unsigned sink_rate = 0;
  int unsigned sink_cycles = 0;

  always @(negedge clk_i) begin : sink_ctrl
    logic rdy;
    rdy = 1'b0;
    sink_cycles++;
    if (sink_cycles % 40 == 0) sink_rate = $urandom_range(0, 3);
    if (hold_left != 0) begin
      hold_left--;
    end else if (!hold_done && inputs_taken >= 40) begin
      // long hold-off while the sender keeps pushing: the block must back up
      hold_done = 1'b1;
      hold_left = 400;
    end else if (sink_stall != 0) begin
      sink_stall--;
    end else if (!calm_tail && sink_rate != 0 && $urandom_range(0, 7) < sink_rate) begin
      sink_stall = $urandom_range(0, 16);
    end else begin
      rdy = 1'b1;
    end
    m_axis_tready <= rdy;
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin : mon
    postfix_sym_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        convert_char(s_axis_tdata, s_axis_tlast);
        inputs_taken++;
        calm_tail = (inputs_taken + 30 >= total_items);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_syms.size() == 0) begin
          flag_mismatch($sformatf("unexpected result data=%h user=%b last=%b",
                                  m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end else begin
          want = pending_syms.pop_front();
          if (m_axis_tdata !== want.symbol)
            flag_mismatch($sformatf("symbol %h, want %h", m_axis_tdata, want.symbol));
          if (m_axis_tuser[0] !== want.has_symbol)
            flag_mismatch($sformatf("has_symbol %b, want %b", m_axis_tuser[0],
                                    want.has_symbol));
          if (m_axis_tuser[1] !== want.bad_expr)
            flag_mismatch($sformatf("bad_expr %b, want %b", m_axis_tuser[1], want.bad_expr));
          if (m_axis_tlast !== want.end_of_expr)
            flag_mismatch($sformatf("end_of_expr %b, want %b", m_axis_tlast,
                                    want.end_of_expr));
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin : sequencer
    int exprs;
    exprs = 0;
    // directed: every operator and bracket, operand extremes, blanks
    add_string("(A+9)*z ^Z/a\t-0");
    add_string(")x");                       // close bracket with nothing open
    add_string("(y");                       // open bracket left at the end
    add_string(" ");                        // last char gives no symbol
    draft = '{8'hFF, 8'h00, 8'h80};         // ignored codes, empty ending
    commit_draft(1'b0);
    gen_deep(18);                           // guaranteed stack overflow
    commit_draft(1'b0);
    while (item_q.size() < 166) begin
      if ($urandom_range(0, 9) == 0) gen_deep($urandom_range(6, 20));
      else gen_expr(0);
      if ($urandom_range(0, 4) == 0) corrupt();
      exprs++;
      commit_draft(exprs == 12);            // one pause until the output runs dry
    end
    total_items = item_q.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (inputs_taken < total_items || pending_syms.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("infix_to_postfix_converter_top regression: pass");
    end else begin
      $display("infix_to_postfix_converter_top regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("infix_to_postfix_converter_top regression: fail");
    $finish;
  end

endmodule

FILE: files.f
rtl/itp_pkg.sv
rtl/itp_stack.sv
rtl/infix_to_postfix_converter_top.sv
tb/infix_to_postfix_converter_top_tb.sv
